// ----- design/positional_pid_deadband_top_assert.svh -----
// Assertion macros for the positional PID top level
`ifndef POSITIONAL_PID_DEADBAND_TOP_ASSERT_SVH
`define POSITIONAL_PID_DEADBAND_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset
`define PPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PPD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/ppd_pkg.sv -----
// Shared types, widths and constants of the positional PID block
`timescale 1ns / 1ps

package ppd_pkg;

  localparam int SampleW      = 16;
  localparam int GainW        = 16;
  localparam int ErrW         = SampleW + 1;
  localparam int DiffW        = ErrW + 1;
  localparam int SumW         = 32;
  localparam int AccW         = SumW + 1;
  localparam int PTermW       = GainW + ErrW;
  localparam int ITermW       = GainW + SumW;
  localparam int DTermW       = GainW + DiffW;
  localparam int TotalW       = ITermW + 2;
  localparam int LimitW       = 31;
  localparam int DeadbandW    = 16;
  localparam int DriveW       = 32;
  localparam int GainFracBits = 8;

  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 5;
  localparam int RegIdxW  = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_UPPER = 3'd3,
    REG_INTEGRAL_LOWER = 3'd4,
    REG_OUTPUT_LIMIT   = 3'd5,
    REG_DEADBAND       = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [GainW-1:0]  gain_p;
    logic signed [GainW-1:0]  gain_i;
    logic signed [GainW-1:0]  gain_d;
    logic signed [SumW-1:0]   integral_upper;
    logic signed [SumW-1:0]   integral_lower;
    logic [LimitW-1:0]        output_limit;
    logic [DeadbandW-1:0]     deadband;
  } cfg_t;

  localparam logic signed [GainW-1:0] GainPRst         = 16'sd256;
  localparam logic signed [GainW-1:0] GainIRst         = 16'sd0;
  localparam logic signed [GainW-1:0] GainDRst         = 16'sd0;
  localparam logic signed [SumW-1:0]  IntegralUpperRst = 32'sd1000000;
  localparam logic signed [SumW-1:0]  IntegralLowerRst = -32'sd1000000;
  localparam logic [LimitW-1:0]       OutputLimitRst   = 31'd16384;
  localparam logic [DeadbandW-1:0]    DeadbandRst      = 16'd1;

endpackage

// ----- design/ppd_regs.sv -----
// Configuration register file with APB-style access
`timescale 1ns / 1ps

module ppd_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ppd_pkg::CfgDataW-1:0]  pwdata,
  output logic [ppd_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output ppd_pkg::cfg_t                 cfg_o
);
  import ppd_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_GAIN_P:         cfg_d.gain_p         = $signed(pwdata[GainW-1:0]);
        REG_GAIN_I:         cfg_d.gain_i         = $signed(pwdata[GainW-1:0]);
        REG_GAIN_D:         cfg_d.gain_d         = $signed(pwdata[GainW-1:0]);
        REG_INTEGRAL_UPPER: cfg_d.integral_upper = $signed(pwdata[SumW-1:0]);
        REG_INTEGRAL_LOWER: cfg_d.integral_lower = $signed(pwdata[SumW-1:0]);
        REG_OUTPUT_LIMIT:   cfg_d.output_limit   = pwdata[LimitW-1:0];
        REG_DEADBAND:       cfg_d.deadband       = pwdata[DeadbandW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_P:         prdata = {{(CfgDataW-GainW){1'b0}}, cfg_q.gain_p};
      REG_GAIN_I:         prdata = {{(CfgDataW-GainW){1'b0}}, cfg_q.gain_i};
      REG_GAIN_D:         prdata = {{(CfgDataW-GainW){1'b0}}, cfg_q.gain_d};
      REG_INTEGRAL_UPPER: prdata = cfg_q.integral_upper;
      REG_INTEGRAL_LOWER: prdata = cfg_q.integral_lower;
      REG_OUTPUT_LIMIT:   prdata = {{(CfgDataW-LimitW){1'b0}}, cfg_q.output_limit};
      REG_DEADBAND:       prdata = {{(CfgDataW-DeadbandW){1'b0}}, cfg_q.deadband};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= GainPRst;
      cfg_q.gain_i         <= GainIRst;
      cfg_q.gain_d         <= GainDRst;
      cfg_q.integral_upper <= IntegralUpperRst;
      cfg_q.integral_lower <= IntegralLowerRst;
      cfg_q.output_limit   <= OutputLimitRst;
      cfg_q.deadband       <= DeadbandRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/ppd_err.sv -----
// Error stage: error, clamped integral and error history update
`timescale 1ns / 1ps

module ppd_err (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic signed [ppd_pkg::SampleW-1:0]  setpoint_i,
  input  logic signed [ppd_pkg::SampleW-1:0]  measured_i,
  input  ppd_pkg::cfg_t                       cfg_i,
  output logic signed [ppd_pkg::ErrW-1:0]     err_o,
  output logic signed [ppd_pkg::SumW-1:0]     error_sum_o,
  output logic signed [ppd_pkg::DiffW-1:0]    diff_o
);
  import ppd_pkg::*;

  logic signed [SumW-1:0]  error_sum_q, error_sum_d;
  logic signed [ErrW-1:0]  last_error_q, older_error_q;
  logic signed [ErrW-1:0]  err_q, err_d;
  logic signed [DiffW-1:0] diff_q, diff_d;
  logic signed [AccW-1:0]  acc, acc_hi, acc_lo;

  always_comb begin
    err_d  = ErrW'(setpoint_i) - ErrW'(measured_i);
    diff_d = DiffW'(last_error_q) - DiffW'(older_error_q);
    acc    = AccW'(error_sum_q) + AccW'(err_d);
    // upper clamp first, so crossed limits settle on the lower one
    acc_hi = (acc > AccW'(cfg_i.integral_upper)) ? AccW'(cfg_i.integral_upper) : acc;
    acc_lo = (acc_hi < AccW'(cfg_i.integral_lower)) ? AccW'(cfg_i.integral_lower) : acc_hi;
    error_sum_d = acc_lo[SumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q   <= '0;
      last_error_q  <= '0;
      older_error_q <= '0;
    end else if (load_i) begin
      error_sum_q   <= error_sum_d;
      last_error_q  <= err_d;
      older_error_q <= last_error_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
  end

  assign err_o       = err_q;
  assign error_sum_o = error_sum_q;
  assign diff_o      = diff_q;

endmodule

// ----- design/ppd_mul.sv -----
// Product stage: the three gain products and the deadband flag
`timescale 1ns / 1ps

module ppd_mul (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  ppd_pkg::cfg_t                       cfg_i,
  input  logic signed [ppd_pkg::ErrW-1:0]     err_i,
  input  logic signed [ppd_pkg::SumW-1:0]     error_sum_i,
  input  logic signed [ppd_pkg::DiffW-1:0]    diff_i,
  output logic signed [ppd_pkg::PTermW-1:0]   p_term_o,
  output logic signed [ppd_pkg::ITermW-1:0]   i_term_o,
  output logic signed [ppd_pkg::DTermW-1:0]   d_term_o,
  output logic                                dead_o
);
  import ppd_pkg::*;

  logic signed [PTermW-1:0] p_term_q, p_term_d;
  logic signed [ITermW-1:0] i_term_q, i_term_d;
  logic signed [DTermW-1:0] d_term_q, d_term_d;
  logic [ErrW-1:0]          mag;
  logic                     dead_q, dead_d;

  always_comb begin
    p_term_d = PTermW'(cfg_i.gain_p) * PTermW'(err_i);
    i_term_d = ITermW'(cfg_i.gain_i) * ITermW'(error_sum_i);
    d_term_d = DTermW'(cfg_i.gain_d) * DTermW'(diff_i);
    mag      = err_i[ErrW-1] ? ErrW'(-err_i) : ErrW'(err_i);
    dead_d   = mag < {1'b0, cfg_i.deadband};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_term_q <= p_term_d;
      i_term_q <= i_term_d;
      d_term_q <= d_term_d;
      dead_q   <= dead_d;
    end
  end

  assign p_term_o = p_term_q;
  assign i_term_o = i_term_q;
  assign d_term_o = d_term_q;
  assign dead_o   = dead_q;

endmodule

// ----- design/ppd_sat.sv -----
// Output stage: sum, fraction shift, saturation and deadband into the result register
`timescale 1ns / 1ps

module ppd_sat (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  ppd_pkg::cfg_t                       cfg_i,
  input  logic signed [ppd_pkg::PTermW-1:0]   p_term_i,
  input  logic signed [ppd_pkg::ITermW-1:0]   i_term_i,
  input  logic signed [ppd_pkg::DTermW-1:0]   d_term_i,
  input  logic                                dead_i,
  output logic signed [ppd_pkg::DriveW-1:0]   drive_o
);
  import ppd_pkg::*;

  logic signed [TotalW-1:0] total, shifted, lim_pos, lim_neg;
  logic signed [DriveW-1:0] drive_q, drive_d;

  always_comb begin
    total   = TotalW'(p_term_i) + TotalW'(i_term_i) + TotalW'(d_term_i);
    shifted = total >>> GainFracBits;   // floor division
    lim_pos = $signed({{(TotalW-LimitW){1'b0}}, cfg_i.output_limit});
    lim_neg = -lim_pos;
    if (dead_i) begin
      drive_d = '0;
    end else if (shifted > lim_pos) begin
      drive_d = lim_pos[DriveW-1:0];
    end else if (shifted < lim_neg) begin
      drive_d = lim_neg[DriveW-1:0];
    end else begin
      drive_d = shifted[DriveW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

// ----- design/positional_pid_deadband_top.sv -----
// Positional PID controller with integral clamp, output limit and deadband
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata[15:0] setpoint, tdata[31:16] measured
//  m_axis   | out       | tdata[31:0] drive
//  apb      | cfg       | gains, integral clamps, output limit, deadband
//
// One item per cycle sustained while m_axis_tready is high; an item reaches tvalid through the stages below.
// Stages: input register, error/integral update, products, sum and saturation.
// The integral and error history update in the error stage, so successive
// items chain with no bubble. Reset clears the valid bits, the integral and the error history.
// Each stage holds while the next is full and not moving, so m_axis stalls back up stage by stage.
`timescale 1ns / 1ps

`include "positional_pid_deadband_top_assert.svh"

module positional_pid_deadband_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // [15:0] setpoint, [31:16] measured
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [31:0] drive
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ppd_pkg::CfgDataW-1:0]  pwdata,
  output logic [ppd_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import ppd_pkg::*;

  cfg_t cfg;

  logic v0_q, v1_q, v2_q, v3_q;
  logic v0_d, v1_d, v2_d, v3_d;
  logic adv0, adv1, adv2, adv3;
  logic s_acc;

  logic signed [SampleW-1:0] setpoint_q, measured_q;
  logic signed [ErrW-1:0]    err;
  logic signed [SumW-1:0]    error_sum;
  logic signed [DiffW-1:0]   diff;
  logic signed [PTermW-1:0]  p_term;
  logic signed [ITermW-1:0]  i_term;
  logic signed [DTermW-1:0]  d_term;
  logic                      dead;
  logic signed [DriveW-1:0]  drive;
  logic signed [DriveW-1:0]  limit_s;

  // a stage moves on when the next one is empty or moving too
  assign adv3  = v3_q & m_axis_tready;
  assign adv2  = v2_q & (~v3_q | adv3);
  assign adv1  = v1_q & (~v2_q | adv2);
  assign adv0  = v0_q & (~v1_q | adv1);
  assign s_axis_tready = ~v0_q | adv0;
  assign s_acc = s_axis_tvalid & s_axis_tready;

  assign v0_d = s_acc | (v0_q & ~adv0);
  assign v1_d = adv0  | (v1_q & ~adv1);
  assign v2_d = adv1  | (v2_q & ~adv2);
  assign v3_d = adv2  | (v3_q & ~adv3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      setpoint_q <= $signed(s_axis_tdata[SampleW-1:0]);
      measured_q <= $signed(s_axis_tdata[2*SampleW-1:SampleW]);
    end
  end

  ppd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppd_err u_err (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv0),
    .setpoint_i  (setpoint_q),
    .measured_i  (measured_q),
    .cfg_i       (cfg),
    .err_o       (err),
    .error_sum_o (error_sum),
    .diff_o      (diff)
  );

  ppd_mul u_mul (
    .clk_i       (clk_i),
    .load_i      (adv1),
    .cfg_i       (cfg),
    .err_i       (err),
    .error_sum_i (error_sum),
    .diff_i      (diff),
    .p_term_o    (p_term),
    .i_term_o    (i_term),
    .d_term_o    (d_term),
    .dead_o      (dead)
  );

  ppd_sat u_sat (
    .clk_i    (clk_i),
    .load_i   (adv2),
    .cfg_i    (cfg),
    .p_term_i (p_term),
    .i_term_i (i_term),
    .d_term_i (d_term),
    .dead_i   (dead),
    .drive_o  (drive)
  );

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = drive;

  assign limit_s = $signed({1'b0, cfg.output_limit});

  `PPD_ASSERT(a_integral_in_range, ($past(adv0) && ($past(cfg.integral_lower) <= $past(cfg.integral_upper))) |-> ((error_sum >= $past(cfg.integral_lower)) && (error_sum <= $past(cfg.integral_upper))), "integral left its clamp range")
  `PPD_ASSERT_NEXT(a_drive_limited, adv2, ((drive <= $past(limit_s)) && (drive >= -$past(limit_s))), "drive exceeds output limit")
  `PPD_ASSERT_NEXT(a_deadband_zero, adv2 && dead, drive == '0, "drive not zero inside deadband")

endmodule
